/* hw/rtl/assert_macros.svh */
// Assertion helpers for the running-median block.
// Each macro checks on the rising edge of clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define RMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define RMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent at the next edge.
`define RMH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rmh_pkg.sv */
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared types for the running-median (two heaps) block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmh_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PUSH_CMP,
    ST_BAL,
    ST_POP,
    ST_POP_LAST,
    ST_POP_DOWN,
    ST_POP_L,
    ST_POP_R,
    ST_POP_CMP,
    ST_FIN
  } rmh_state_t;

endpackage

`default_nettype wire

/* hw/rtl/rmh_in_if.sv */
// ----------------------------------------------------------------------------
// rmh_in_if
// Request channel carrying one signed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmh_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rmh_out_if.sv */
// ----------------------------------------------------------------------------
// rmh_out_if
// Result channel: lower median, held count and drop flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmh_out_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 11
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] median;
  logic [COUNT_WIDTH-1:0] held_count;
  logic                   dropped;

  modport source (output valid, output median, output held_count, output dropped,
                  input ready);
  modport sink   (input valid, input median, input held_count, input dropped,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/running_median_two_heaps_top.sv */
// Path to results.valid: a dropped request goes straight to the result step; an
//   insert sifts up level by level, and a rebalance also pops a root, sifts the
//   refill down and re-inserts the popped top into the other heap.
// Throughput: one request in flight; ready returns right after the result is
//   registered, and a result still waiting stalls the next request's last step.
// Reset: rst (synchronous) clears the counts; heap RAM is read only below them.
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running lower median kept as a max-heap (lower half) and a min-heap (upper
// half) in two RAMs, walked one level at a time by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module running_median_two_heaps_top #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  rmh_in_if.sink    samples,
  rmh_out_if.source results
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // Heap RAMs, values in offset binary so unsigned compare orders them.
  logic [VALUE_WIDTH-1:0] lo_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] up_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] lo_rd, up_rd, rd;

  rmh_pkg::rmh_state_t state, state_next;

  // sel: 1 = lower (max) heap is the one being walked
  logic                   sel, sel_next;
  logic [AW-1:0]          idx, idx_next;      // hole position
  logic [CW-1:0]          nval, nval_next;    // size after pop
  logic [VALUE_WIDTH-1:0] val, val_next;      // value being inserted / popped top
  logic [VALUE_WIDTH-1:0] last, last_next;    // element sinking down on pop
  logic [AW-1:0]          best, best_next;
  logic [VALUE_WIDTH-1:0] bval, bval_next;
  logic [CW-1:0]          lc, lc_next, uc, uc_next;
  logic [VALUE_WIDTH-1:0] lroot, lroot_next, uroot, uroot_next;
  logic                   drop, drop_next;
  logic                   ov, ov_next;
  logic [VALUE_WIDTH-1:0] med, med_next;
  logic [CW-1:0]          hc, hc_next;
  logic                   odrop, odrop_next;  // drop flag of the result on offer

  // memory port controls
  logic                   we;
  logic [AW-1:0]          wa, ra;
  logic [VALUE_WIDTH-1:0] wd;

  // scratch
  logic [VALUE_WIDTH-1:0] key;
  logic [CW-1:0]          total;
  logic [AW:0]            lchild, rchild;
  logic                   bal_ok;
  logic                   in_fire;

  function automatic logic ranks_above(input logic [VALUE_WIDTH-1:0] a,
                                       input logic [VALUE_WIDTH-1:0] b,
                                       input logic                   is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction

  always_ff @(posedge clk) begin
    if (we && sel) begin
      lo_mem[wa] <= wd;
    end
    if (we && !sel) begin
      up_mem[wa] <= wd;
    end
    lo_rd <= lo_mem[ra];
    up_rd <= up_mem[ra];
  end

  assign rd    = sel ? lo_rd : up_rd;
  assign key   = samples.sample ^ SIGN;
  assign total = lc + uc;
  assign lchild = {idx, 1'b1};
  assign rchild = lchild + 1'b1;
  assign bal_ok = ({1'b0, lc} <= {1'b0, uc} + 1'b1) && ({1'b0, uc} <= {1'b0, lc} + 1'b1);
  assign in_fire = samples.valid && samples.ready;

  assign samples.ready      = (state == rmh_pkg::ST_IDLE);
  assign results.valid      = ov;
  assign results.median     = med;
  assign results.held_count = hc;
  assign results.dropped    = odrop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmh_pkg::ST_IDLE;
      lc    <= '0;
      uc    <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      lc    <= lc_next;
      uc    <= uc_next;
      ov    <= ov_next;
    end
    sel   <= sel_next;
    idx   <= idx_next;
    nval  <= nval_next;
    val   <= val_next;
    last  <= last_next;
    best  <= best_next;
    bval  <= bval_next;
    lroot <= lroot_next;
    uroot <= uroot_next;
    drop  <= drop_next;
    med   <= med_next;
    hc    <= hc_next;
    odrop <= odrop_next;
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    idx_next   = idx;
    nval_next  = nval;
    val_next   = val;
    last_next  = last;
    best_next  = best;
    bval_next  = bval;
    lc_next    = lc;
    uc_next    = uc;
    lroot_next = lroot;
    uroot_next = uroot;
    drop_next  = drop;
    ov_next    = ov && !results.ready;
    med_next   = med;
    hc_next    = hc;
    odrop_next = odrop;
    we         = 1'b0;
    wa         = idx;
    wd         = val;
    ra         = idx;

    case (state)
      rmh_pkg::ST_IDLE: begin
        if (samples.valid) begin
          if (total >= CAP) begin
            drop_next  = 1'b1;
            state_next = rmh_pkg::ST_FIN;
          end else begin
            drop_next = 1'b0;
            val_next  = key;
            // ties go to the lower heap
            if (lc == '0 || key <= lroot) begin
              sel_next = 1'b1;
              idx_next = lc[AW-1:0];
              lc_next  = lc + 1'b1;
            end else begin
              sel_next = 1'b0;
              idx_next = uc[AW-1:0];
              uc_next  = uc + 1'b1;
            end
            state_next = rmh_pkg::ST_PUSH;
          end
        end
      end

      // sift up: hole at idx, compare against parent
      rmh_pkg::ST_PUSH: begin
        if (idx == '0) begin
          we = 1'b1;
          wa = '0;
          wd = val;
          if (sel) lroot_next = val;
          else     uroot_next = val;
          state_next = rmh_pkg::ST_BAL;
        end else begin
          ra         = (idx - 1'b1) >> 1;
          state_next = rmh_pkg::ST_PUSH_CMP;
        end
      end

      rmh_pkg::ST_PUSH_CMP: begin
        we = 1'b1;
        wa = idx;
        if (ranks_above(val, rd, sel)) begin
          wd         = rd;
          idx_next   = (idx - 1'b1) >> 1;
          state_next = rmh_pkg::ST_PUSH;
        end else begin
          wd         = val;
          state_next = rmh_pkg::ST_BAL;
        end
      end

      rmh_pkg::ST_BAL: begin
        if ({1'b0, lc} > {1'b0, uc} + 1'b1) begin
          sel_next   = 1'b1;
          state_next = rmh_pkg::ST_POP;
        end else if ({1'b0, uc} > {1'b0, lc} + 1'b1) begin
          sel_next   = 1'b0;
          state_next = rmh_pkg::ST_POP;
        end else begin
          state_next = rmh_pkg::ST_FIN;
        end
      end

      // pop root; refill from the last entry and sift it down
      rmh_pkg::ST_POP: begin
        val_next = sel ? lroot : uroot;
        if (sel) begin
          nval_next = lc - 1'b1;
          lc_next   = lc - 1'b1;
        end else begin
          nval_next = uc - 1'b1;
          uc_next   = uc - 1'b1;
        end
        ra         = nval_next[AW-1:0];
        idx_next   = '0;
        state_next = rmh_pkg::ST_POP_LAST;
      end

      rmh_pkg::ST_POP_LAST: begin
        last_next  = rd;
        state_next = rmh_pkg::ST_POP_DOWN;
      end

      rmh_pkg::ST_POP_DOWN: begin
        if (lchild >= {1'b0, nval}) begin
          we = 1'b1;
          wa = idx;
          wd = last;
          if (idx == '0) begin
            if (sel) lroot_next = last;
            else     uroot_next = last;
          end
          // re-insert popped top into the other heap
          sel_next = !sel;
          if (sel) begin
            idx_next = uc[AW-1:0];
            uc_next  = uc + 1'b1;
          end else begin
            idx_next = lc[AW-1:0];
            lc_next  = lc + 1'b1;
          end
          state_next = rmh_pkg::ST_PUSH;
        end else begin
          ra         = lchild[AW-1:0];
          state_next = rmh_pkg::ST_POP_L;
        end
      end

      rmh_pkg::ST_POP_L: begin
        best_next = lchild[AW-1:0];
        bval_next = rd;
        if (rchild < {1'b0, nval}) begin
          ra         = rchild[AW-1:0];
          state_next = rmh_pkg::ST_POP_R;
        end else begin
          state_next = rmh_pkg::ST_POP_CMP;
        end
      end

      rmh_pkg::ST_POP_R: begin
        if (ranks_above(rd, bval, sel)) begin
          best_next = rchild[AW-1:0];
          bval_next = rd;
        end
        state_next = rmh_pkg::ST_POP_CMP;
      end

      rmh_pkg::ST_POP_CMP: begin
        if (ranks_above(bval, last, sel)) begin
          we = 1'b1;
          wa = idx;
          wd = bval;
          if (idx == '0) begin
            if (sel) lroot_next = bval;
            else     uroot_next = bval;
          end
          idx_next = best;
        end
        // when last stays, the next DOWN pass sees no child and finishes
        if (!ranks_above(bval, last, sel)) begin
          nval_next = {1'b0, idx} >= nval ? nval : CW'({1'b0, idx});
        end
        state_next = rmh_pkg::ST_POP_DOWN;
      end

      rmh_pkg::ST_FIN: begin
        if (!ov || results.ready) begin
          ov_next    = 1'b1;
          hc_next    = total;
          odrop_next = drop;
          med_next   = ((lc >= uc) ? lroot : uroot) ^ SIGN;
          if (total == '0) med_next = '0;
          state_next = rmh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rmh_pkg::ST_IDLE;
      end
    endcase
  end

  // Heaps stay balanced between requests.
  `RMH_ASSERT_IMP(a_balanced, state == rmh_pkg::ST_IDLE, bal_ok, "heaps out of balance")
  // Never more than CAPACITY held.
  `RMH_ASSERT(a_cap, ({1'b0, lc} + {1'b0, uc}) <= {1'b0, CAP}, "held count above capacity")
  // A drop is only reported with storage full.
  `RMH_ASSERT_IMP(a_drop_full, ov && odrop, hc == CAP, "drop reported while not full")
  // An accepted request starts the sequencer.
  `RMH_ASSERT_NXT(a_busy, in_fire, state != rmh_pkg::ST_IDLE, "sequencer idle after request")

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed samples into the running-median block and checks every result
// (median, held count, drop flag) against a sorted-list predictor kept here.
// Covers extremes, ties, sign crossings, and a refill after nothing waits.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int CAP    = 1024;
  localparam int VW     = 32;
  localparam int CW     = 11;
  localparam int WDOG   = 20000;

  typedef struct packed {
    logic [VW-1:0] median;
    logic [CW-1:0] held_count;
    logic          dropped;
  } median_res_t;

  logic clk;
  logic rst;

  rmh_in_if  #(.VALUE_WIDTH(VW))                   samples_if ();
  rmh_out_if #(.VALUE_WIDTH(VW), .COUNT_WIDTH(CW)) results_if ();

  running_median_two_heaps_top #(.CAPACITY(CAP), .VALUE_WIDTH(VW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if.sink),
    .results (results_if.source)
  );

  // Predictor state: the held samples kept sorted; the lower median is the
  // ((n+1)/2)-th smallest, which equals what the two heaps would report.
  logic signed [VW-1:0] held_sorted[$];
  median_res_t          expected_q[$];
  logic [VW-1:0]        pending_q[$];

  int  mismatches;
  int  idle_cycles;
  bit  drain_hold;   // sender holds back new requests while set
  bit  calm;         // stretch with no idling on either side

  function automatic median_res_t predict_median(logic signed [VW-1:0] s);
    median_res_t r;
    int pos;
    r.dropped = 1'b0;
    if (held_sorted.size() >= CAP) begin
      r.dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < held_sorted.size() && held_sorted[pos] <= s) pos++;
      held_sorted.insert(pos, s);
    end
    r.held_count = CW'(held_sorted.size());
    r.median     = held_sorted[(held_sorted.size() + 1) / 2 - 1];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: requests come from pending_q; the prediction is made on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid  <= 1'b0;
      samples_if.sample <= '0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        expected_q.push_back(predict_median(samples_if.sample));
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (pending_q.size() > 0 && !drain_hold &&
            (calm || $urandom_range(99) >= 14)) begin
          samples_if.valid  <= 1'b1;
          samples_if.sample <= pending_q.pop_front();
        end else begin
          samples_if.valid  <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result with the oldest prediction.
  always @(posedge clk) begin
    median_res_t got, exp_r;
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= calm || ($urandom_range(99) >= 14);
      if (results_if.valid && results_if.ready) begin
        got.median     = results_if.median;
        got.held_count = results_if.held_count;
        got.dropped    = results_if.dropped;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: median=%0d count=%0d dropped=%0b",
                     $signed(got.median), got.held_count, got.dropped);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            // fields: median, held count, dropped
            if (mismatches <= 10)
              $display("result mismatch: exp (%0d,%0d,%0b) got (%0d,%0d,%0b)",
                       $signed(exp_r.median), exp_r.held_count, exp_r.dropped,
                       $signed(got.median), got.held_count, got.dropped);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG) begin
      $display("running_median_two_heaps_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [VW-1:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return VW'($signed($urandom_range(40)) - 20);   // many ties
      default: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom_range(255))};
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || samples_if.valid || expected_q.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int mode;
    mismatches  = 0;
    idle_cycles = 0;
    drain_hold  = 1'b0;
    calm        = 1'b0;
    rst               = 1'b1;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    results_if.ready  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, ties, sign crossings, alternating sides.
    pending_q.push_back(32'h8000_0000);
    pending_q.push_back(32'h7FFF_FFFF);
    pending_q.push_back(32'h0000_0000);
    pending_q.push_back(32'hFFFF_FFFF);
    pending_q.push_back(32'h0000_0001);
    pending_q.push_back(32'h0000_0000);
    pending_q.push_back(32'h0000_0000);
    pending_q.push_back(32'h8000_0000);
    pending_q.push_back(32'h7FFF_FFFF);
    pending_q.push_back(32'h5555_5555);
    pending_q.push_back(32'hAAAA_AAAA);
    for (int i = 0; i < 8; i++) pending_q.push_back(32'(i * 3 - 12));
    wait_drained();

    // Pause with nothing outstanding, then a calm stretch.
    drain_hold = 1'b1;
    repeat (20) @(posedge clk);
    drain_hold = 1'b0;
    calm = 1'b1;
    for (int i = 0; i < 100; i++) pending_q.push_back(rand_sample(0));
    wait_drained();
    calm = 1'b0;

    // Random mix of wide values, ties, and small positives or values near the negative extreme.
    for (int i = 0; i < 630; i++) begin
      mode = $urandom_range(2);
      pending_q.push_back(rand_sample(mode));
    end
    // Extremes once more at the end.
    pending_q.push_back(32'h8000_0000);
    pending_q.push_back(32'h7FFF_FFFF);
    wait_drained();

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("running_median_two_heaps_top: match");
    end else begin
      $display("running_median_two_heaps_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/rmh_pkg.sv
hw/rtl/rmh_in_if.sv
hw/rtl/rmh_out_if.sv
hw/rtl/running_median_two_heaps_top.sv
dv/testbench.sv
